// ===== src/mice_pkg.sv =====
// ----------------------------------------------------------------------------
// mice_pkg
// Shared types, register indexes and encoding constants of the Mic-E
// position encoder.
// ----------------------------------------------------------------------------
package mice_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_MESSAGE_BITS    = 3'd0;
   localparam logic [2:0] CSR_CUSTOM_MESSAGE  = 3'd1;
   localparam logic [2:0] CSR_STATION_SSID    = 3'd2;
   localparam logic [2:0] CSR_SYMBOL_CODE     = 3'd3;
   localparam logic [2:0] CSR_ALTERNATE_TABLE = 3'd4;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [7:0] SYMBOL_RESET = 8'd110;

   // ascii letters and encoding offsets
   localparam logic [7:0] ASCII_N = 8'h4E;
   localparam logic [7:0] ASCII_S = 8'h53;
   localparam logic [7:0] ASCII_E = 8'h45;
   localparam logic [7:0] ASCII_W = 8'h57;

   localparam logic [7:0] DIGIT_BASE    = 8'h30;
   localparam logic [7:0] FLAG_ADD      = 8'h20;
   localparam logic [7:0] STD_MSG_ADD   = 8'h20;
   localparam logic [7:0] CUSTOM_MSG_ADD = 8'h11;
   localparam logic [7:0] TABLE_PRIMARY = 8'h2F;
   localparam logic [7:0] TABLE_ALT     = 8'h5C;
   localparam logic [7:0] BYTE_BIAS     = 8'd28;
   localparam logic [7:0] LOW_DEG_BIAS  = 8'd118;
   localparam logic [7:0] LOW_MIN_BIAS  = 8'd88;

   localparam logic [9:0] SPEED_LIMIT  = 10'd800;
   localparam logic [8:0] COURSE_LIMIT = 9'd360;

   localparam logic [2:0] PATH_FULL = 3'd4;
   localparam logic [2:0] PATH_NONE = 3'd0;

   typedef struct packed {
      logic [2:0] message_bits;
      logic       custom_message;
      logic [3:0] station_ssid;
      logic [7:0] symbol_code;
      logic       alternate_table;
   } cfg_type;

   // after field parse and digit weighting
   typedef struct packed {
      logic        bad;
      logic [3:0]  lat_nib0;
      logic [3:0]  lat_nib1;
      logic [3:0]  lat_nib2;
      logic [3:0]  lat_nib3;
      logic [3:0]  lat_nib5;
      logic [3:0]  lat_nib6;
      logic        north;
      logic        west;
      logic [10:0] deg;
      logic [7:0]  mins;
      logic [7:0]  hund;
      logic [9:0]  speed;
      logic [8:0]  course;
   } s1_type;

   // after byte mapping and decimal split
   typedef struct packed {
      logic       bad;
      logic [3:0] lat_nib0;
      logic [3:0] lat_nib1;
      logic [3:0] lat_nib2;
      logic [3:0] lat_nib3;
      logic [3:0] lat_nib5;
      logic [3:0] lat_nib6;
      logic       north;
      logic       west;
      logic       lon_offset;
      logic [7:0] deg_byte;
      logic [7:0] min_byte;
      logic [7:0] hund_byte;
      logic [6:0] spd_tens;
      logic [3:0] spd_units;
      logic [1:0] crs_hundreds;
      logic [6:0] crs_rest;
   } s2_type;

endpackage

// ===== src/mice_chan_if.sv =====
// ----------------------------------------------------------------------------
// mice_chan_if
// Valid/ready channels of the Mic-E position encoder: position requests
// in, encoded responses out.
// ----------------------------------------------------------------------------
interface mice_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] lat_text;
   logic [63:0] lon_text;
   logic [7:0]  lon_hemisphere;
   logic [9:0]  speed_knots;
   logic [8:0]  course_deg;

   modport source (output valid, lat_text, lon_text, lon_hemisphere, speed_knots,
                   course_deg, input ready);
   modport sink   (input valid, lat_text, lon_text, lon_hemisphere, speed_knots,
                   course_deg, output ready);
endinterface

interface mice_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [47:0] dest_chars;
   logic [63:0] info_chars;
   logic [2:0]  path_entries;

   modport source (output valid, status, dest_chars, info_chars, path_entries,
                   input ready);
   modport sink   (input valid, status, dest_chars, info_chars, path_entries,
                   output ready);
endinterface

// ===== src/mice_parse.sv =====
// ----------------------------------------------------------------------------
// mice_parse
// First stage: hemisphere check, digit extraction, speed/course clamp and
// weighting of the degree, minute and hundredth digits.
// ----------------------------------------------------------------------------
module mice_parse (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [63:0]    lat_text,
   input  logic [63:0]    lon_text,
   input  logic [7:0]     lon_hemisphere,
   input  logic [9:0]     speed_knots,
   input  logic [8:0]     course_deg,
   output logic           out_valid,
   input  logic           out_ready,
   output mice_pkg::s1_type out_data
);
   import mice_pkg::*;

   logic   valid_ff;
   logic   valid_in;
   s1_type data_ff;
   s1_type data_in;
   logic [7:0] ns_char;
   logic [3:0] lon_n0, lon_n1, lon_n2, lon_n3, lon_n4, lon_n6, lon_n7;

   assign ns_char = lat_text[7:0];
   assign lon_n0  = lon_text[59:56];
   assign lon_n1  = lon_text[51:48];
   assign lon_n2  = lon_text[43:40];
   assign lon_n3  = lon_text[35:32];
   assign lon_n4  = lon_text[27:24];
   assign lon_n6  = lon_text[11:8];
   assign lon_n7  = lon_text[3:0];

   always_comb begin
      data_in          = '0;
      data_in.bad      = ((ns_char != ASCII_N) && (ns_char != ASCII_S)) ||
                         ((lon_hemisphere != ASCII_E) && (lon_hemisphere != ASCII_W));
      data_in.lat_nib0 = lat_text[59:56];
      data_in.lat_nib1 = lat_text[51:48];
      data_in.lat_nib2 = lat_text[43:40];
      data_in.lat_nib3 = lat_text[35:32];
      data_in.lat_nib5 = lat_text[19:16];
      data_in.lat_nib6 = lat_text[11:8];
      data_in.north    = (ns_char == ASCII_N);
      data_in.west     = (lon_hemisphere == ASCII_W);
      data_in.deg      = {7'd0, lon_n0} * 11'd100 + {7'd0, lon_n1} * 11'd10 +
                         {7'd0, lon_n2};
      data_in.mins     = {4'd0, lon_n3} * 8'd10 + {4'd0, lon_n4};
      data_in.hund     = {4'd0, lon_n6} * 8'd10 + {4'd0, lon_n7};
      data_in.speed    = (speed_knots >= SPEED_LIMIT) ? 10'd0 : speed_knots;
      data_in.course   = (course_deg > COURSE_LIMIT) ? 9'd0 : course_deg;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   a_speed_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.speed < SPEED_LIMIT)
      else $error("speed above limit left the parse stage");
   a_course_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.course <= COURSE_LIMIT)
      else $error("course above limit left the parse stage");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("parse stage lost its item under stall");

endmodule

// ===== src/mice_arith.sv =====
// ----------------------------------------------------------------------------
// mice_arith
// Second stage: longitude bytes with their offset flag, and decimal split of
// speed and course by reciprocal multiplication.
// ----------------------------------------------------------------------------
module mice_arith (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mice_pkg::s1_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mice_pkg::s2_type out_data
);
   import mice_pkg::*;

   logic   valid_ff;
   logic   valid_in;
   s2_type data_ff;
   s2_type data_in;
   logic [17:0] spd_prod;
   logic [14:0] crs_prod;
   logic [6:0]  spd_q;
   logic [1:0]  crs_q;
   logic [9:0]  spd_rem;
   logic [8:0]  crs_rem;
   logic [10:0] deg_sum;

   // x/10 = (x*205)>>11 for x < 1024, x/100 = (x*41)>>12 for x <= 360
   assign spd_prod = {8'd0, in_data.speed} * 18'd205;
   assign crs_prod = {6'd0, in_data.course} * 15'd41;
   assign spd_q    = spd_prod[17:11];
   assign crs_q    = crs_prod[13:12];
   assign spd_rem  = in_data.speed - {3'd0, spd_q} * 10'd10;
   assign crs_rem  = in_data.course - {7'd0, crs_q} * 9'd100;

   always_comb begin
      priority if (in_data.deg < 11'd10) begin
         deg_sum = in_data.deg + {3'd0, LOW_DEG_BIAS};
      end else if (in_data.deg < 11'd100) begin
         deg_sum = in_data.deg + {3'd0, BYTE_BIAS};
      end else if (in_data.deg < 11'd110) begin
         deg_sum = in_data.deg + 11'd8;
      end else begin
         deg_sum = in_data.deg - 11'd72;
      end
   end

   always_comb begin
      data_in              = '0;
      data_in.bad          = in_data.bad;
      data_in.lat_nib0     = in_data.lat_nib0;
      data_in.lat_nib1     = in_data.lat_nib1;
      data_in.lat_nib2     = in_data.lat_nib2;
      data_in.lat_nib3     = in_data.lat_nib3;
      data_in.lat_nib5     = in_data.lat_nib5;
      data_in.lat_nib6     = in_data.lat_nib6;
      data_in.north        = in_data.north;
      data_in.west         = in_data.west;
      data_in.lon_offset   = (in_data.deg < 11'd10) || (in_data.deg >= 11'd100);
      data_in.deg_byte     = deg_sum[7:0];
      data_in.min_byte     = (in_data.mins < 8'd10) ? in_data.mins + LOW_MIN_BIAS
                                                     : in_data.mins + BYTE_BIAS;
      data_in.hund_byte    = in_data.hund + BYTE_BIAS;
      data_in.spd_tens     = spd_q;
      data_in.spd_units    = spd_rem[3:0];
      data_in.crs_hundreds = crs_q;
      data_in.crs_rest     = crs_rem[6:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   a_spd_units: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.spd_units < 4'd10)
      else $error("speed units digit out of range");
   a_crs_rest: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.crs_rest < 7'd100)
      else $error("course remainder out of range");
   a_spd_tens: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.spd_tens < 7'd80)
      else $error("speed tens beyond clamp");

endmodule

// ===== src/mice_pack.sv =====
// ----------------------------------------------------------------------------
// mice_pack
// Last stage: applies message bits and flags to the destination characters,
// builds the info bytes and holds the response in the output register.
// ----------------------------------------------------------------------------
module mice_pack (
   input  logic             clock,
   input  logic             reset,
   input  mice_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  mice_pkg::s2_type in_data,
   mice_rsp_if.source       rsp
);
   import mice_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic        status_ff, status_in;
   logic [47:0] dest_ff, dest_in;
   logic [63:0] info_ff, info_in;
   logic [2:0]  path_ff, path_in;
   logic [7:0]  msg_add;
   logic [7:0]  d0, d1, d2, d3, d4, d5;
   logic [7:0]  b3, b4, b5, b7;

   assign msg_add = cfg.custom_message ? CUSTOM_MSG_ADD : STD_MSG_ADD;

   always_comb begin
      d0 = (DIGIT_BASE | {4'd0, in_data.lat_nib0}) +
           (cfg.message_bits[2] ? msg_add : 8'd0);
      d1 = (DIGIT_BASE | {4'd0, in_data.lat_nib1}) +
           (cfg.message_bits[1] ? msg_add : 8'd0);
      d2 = (DIGIT_BASE | {4'd0, in_data.lat_nib2}) +
           (cfg.message_bits[0] ? msg_add : 8'd0);
      d3 = (DIGIT_BASE | {4'd0, in_data.lat_nib3}) + (in_data.north ? FLAG_ADD : 8'd0);
      d4 = (DIGIT_BASE | {4'd0, in_data.lat_nib5}) +
           (in_data.lon_offset ? FLAG_ADD : 8'd0);
      d5 = (DIGIT_BASE | {4'd0, in_data.lat_nib6}) + (in_data.west ? FLAG_ADD : 8'd0);
      b3 = {1'b0, in_data.spd_tens} + BYTE_BIAS;
      b4 = {4'd0, in_data.spd_units} * 8'd10 + {6'd0, in_data.crs_hundreds} + BYTE_BIAS;
      b5 = {1'b0, in_data.crs_rest} + BYTE_BIAS;
      b7 = cfg.alternate_table ? TABLE_ALT : TABLE_PRIMARY;
   end

   always_comb begin
      if (in_data.bad) begin
         status_in = 1'b1;
         dest_in   = '0;
         info_in   = '0;
         path_in   = PATH_NONE;
      end else begin
         status_in = 1'b0;
         dest_in   = {d0, d1, d2, d3, d4, d5};
         info_in   = {in_data.deg_byte, in_data.min_byte, in_data.hund_byte,
                      b3, b4, b5, cfg.symbol_code, b7};
         path_in   = (cfg.station_ssid == 4'd0) ? PATH_FULL : PATH_NONE;
      end
   end

   assign in_ready         = !valid_ff || rsp.ready;
   assign valid_in         = in_ready ? in_valid : valid_ff;
   assign rsp.valid        = valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.dest_chars   = dest_ff;
   assign rsp.info_chars   = info_ff;
   assign rsp.path_entries = path_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         status_ff <= status_in;
         dest_ff   <= dest_in;
         info_ff   <= info_in;
         path_ff   <= path_in;
      end
   end

   a_bad_zeroed: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff) |->
         (dest_ff == 48'd0 && info_ff == 64'd0 && path_ff == PATH_NONE))
      else $error("error response carries nonzero fields");
   a_table_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !status_ff) |->
         (info_ff[7:0] == TABLE_PRIMARY || info_ff[7:0] == TABLE_ALT))
      else $error("symbol table byte is neither table");
   a_path_ssid: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !status_ff) |->
         (path_ff == ((cfg.station_ssid == 4'd0) ? PATH_FULL : PATH_NONE)))
      else $error("path entry count disagrees with ssid");

endmodule

// ===== src/mic_e_position_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// mic_e_position_encoder_unit
// Encodes one APRS Mic-E position report into destination characters and
// info bytes 1..8.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one position report per item: latitude text, longitude
//   text and hemisphere, speed and course. rsp_ch returns one response per
//   item: status, six destination characters, info bytes and path count.
//   csr_we/csr_index/csr_wdata write the message bits, message mode, ssid,
//   symbol and symbol table; write them only while no item is in flight.
//   A request passes through three registered stages in order: parse and
//   digit weighting, byte mapping with the speed/course decimal split, then
//   packing into the output register. The pipeline takes one item per
//   cycle while rsp_ch accepts responses; each of the three stages holds one
//   item and moves on whenever the stage after it is empty or draining.
//   While rsp_ch stalls the stages fill up and req_ch.ready drops once all
//   three are occupied; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (symbol 'n', primary table, standard message, ssid zero).
// ----------------------------------------------------------------------------
module mic_e_position_encoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   mice_req_if.sink                            req_ch,
   mice_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mice_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mice_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mice_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   s1_type  s1_data;
   s2_type  s2_data;
   logic    s1_valid, s1_ready;
   logic    s2_valid, s2_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MESSAGE_BITS:    cfg_in.message_bits    = csr_wdata[2:0];
            CSR_CUSTOM_MESSAGE:  cfg_in.custom_message  = csr_wdata[0];
            CSR_STATION_SSID:    cfg_in.station_ssid    = csr_wdata[3:0];
            CSR_SYMBOL_CODE:     cfg_in.symbol_code     = csr_wdata;
            CSR_ALTERNATE_TABLE: cfg_in.alternate_table = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.message_bits    <= 3'd0;
         cfg_ff.custom_message  <= 1'b0;
         cfg_ff.station_ssid    <= 4'd0;
         cfg_ff.symbol_code     <= SYMBOL_RESET;
         cfg_ff.alternate_table <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mice_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_ch.valid),
      .in_ready       (req_ch.ready),
      .lat_text       (req_ch.lat_text),
      .lon_text       (req_ch.lon_text),
      .lon_hemisphere (req_ch.lon_hemisphere),
      .speed_knots    (req_ch.speed_knots),
      .course_deg     (req_ch.course_deg),
      .out_valid      (s1_valid),
      .out_ready      (s1_ready),
      .out_data       (s1_data)
   );

   mice_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   mice_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (s2_valid),
      .in_ready (s2_ready),
      .in_data  (s2_data),
      .rsp      (rsp_ch)
   );

endmodule
